/* rtl/mpam_pkg.sv */
// Shared constants, opcodes and state encoding for the multi-pattern matcher.
package mpam_pkg;

  localparam int MAX_NODES = 2048;
  localparam int ALPHABET  = 26;

  localparam int NODE_W = $clog2(MAX_NODES);
  localparam int CNT_W  = NODE_W + 1;
  localparam int IDX_W  = (ALPHABET > 2) ? $clog2(ALPHABET) : 1;
  localparam int ROW_W  = ALPHABET * NODE_W;
  localparam int TERM_W = 16;
  localparam int HIT_W  = 32;
  localparam int OP_W   = 3;
  localparam int SYM_W  = 5;

  typedef enum logic [OP_W-1:0] {
    OP_CLEAR = 3'd0,
    OP_PAT   = 3'd1,
    OP_END   = 3'd2,
    OP_BUILD = 3'd3,
    OP_SCAN  = 3'd4,
    OP_READ  = 3'd5
  } op_t;

  typedef enum logic [4:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_INS_WB,
    ST_TERM_WB,
    ST_READ_WB,
    ST_SCAN_ROW,
    ST_WALK_RD,
    ST_WALK_WB,
    ST_B_SWEEP,
    ST_B_INIT,
    ST_B_ROWU,
    ST_B_ROWF,
    ST_B_SYM,
    ST_B_SEEN,
    ST_B_WRROW,
    ST_B_POP,
    ST_B_GETU,
    ST_B_GETF
  } state_t;

endpackage

/* rtl/mpam_ram.sv */
// Generic single-port RAM with registered read data.
module mpam_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic                     we,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

/* rtl/multi_pattern_automaton_matcher.sv */
// Aho-Corasick matcher top level: sequencer around the node, link, count and queue memories.
//
// One request at a time; each returns exactly one result. Pattern symbol, end pattern and
// read hits do one memory read, then a write-back step. Unused opcodes answer from idle.
// A scan symbol reads the child row, then for each node on the failure chain does a read,
// then a saturating hit-counter write-back. Clear sweeps the child, failure, terminal-count
// and hit-count memories one row a cycle; the same sweep runs after reset and no request is
// taken until it ends. Build first clears the visited bits, then for each queued node reads
// its own and its failure node's child rows, visits every letter once, and takes an extra
// step on each letter that leads to a child candidate.
module multi_pattern_automaton_matcher import mpam_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [OP_W-1:0]     in_opcode,
  input  logic [SYM_W-1:0]    in_symbol,
  input  logic [NODE_W-1:0]   in_node_select,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [NODE_W-1:0]   out_node,
  output logic [TERM_W-1:0]   out_matches_here,
  output logic [HIT_W-1:0]    out_hit_count,
  output logic                out_error_code
);

  state_t state_r, state_nxt;

  logic [SYM_W-1:0]  sym_r, sym_nxt;
  logic [NODE_W-1:0] sel_r, sel_nxt;
  logic [NODE_W-1:0] ins_r, ins_nxt;
  logic [NODE_W-1:0] scan_r, scan_nxt;
  logic [CNT_W-1:0]  nu_r, nu_nxt;
  logic [CNT_W-1:0]  addr_r, addr_nxt;
  logic              reply_r, reply_nxt;
  logic [NODE_W-1:0] k_r, k_nxt;
  logic [CNT_W-1:0]  steps_r, steps_nxt;
  logic [TERM_W-1:0] match_r, match_nxt;
  logic [CNT_W-1:0]  head_r, head_nxt;
  logic [CNT_W-1:0]  tail_r, tail_nxt;
  logic [NODE_W-1:0] u_r, u_nxt;
  logic [NODE_W-1:0] f_r, f_nxt;
  logic              root_r, root_nxt;
  logic [IDX_W-1:0]  idx_r, idx_nxt;
  logic [ROW_W-1:0]  rowu_r, rowu_nxt;
  logic [ROW_W-1:0]  rowf_r, rowf_nxt;
  logic [NODE_W-1:0] c_r, c_nxt;
  logic [NODE_W-1:0] g_r, g_nxt;

  logic              out_valid_r;
  logic [NODE_W-1:0] out_node_r, out_node_nxt;
  logic [TERM_W-1:0] out_match_r, out_match_nxt;
  logic [HIT_W-1:0]  out_hit_r, out_hit_nxt;
  logic              out_err_r, out_err_nxt;
  logic              fin;

  // memory ports
  logic [NODE_W-1:0] ch_addr, fl_addr, tc_addr, hc_addr, q_addr, sn_addr;
  logic              ch_we, fl_we, tc_we, hc_we, q_we, sn_we;
  logic [ROW_W-1:0]  ch_wdata, ch_rdata;
  logic [NODE_W-1:0] fl_wdata, fl_rdata, q_wdata, q_rdata;
  logic [TERM_W-1:0] tc_wdata, tc_rdata;
  logic [HIT_W-1:0]  hc_wdata, hc_rdata;
  logic              sn_wdata, sn_rdata;

  mpam_ram #(.WIDTH(ROW_W), .DEPTH(MAX_NODES)) u_child (
    .clk(clk), .addr(ch_addr), .we(ch_we), .wdata(ch_wdata), .rdata(ch_rdata));
  mpam_ram #(.WIDTH(NODE_W), .DEPTH(MAX_NODES)) u_fail (
    .clk(clk), .addr(fl_addr), .we(fl_we), .wdata(fl_wdata), .rdata(fl_rdata));
  mpam_ram #(.WIDTH(TERM_W), .DEPTH(MAX_NODES)) u_term (
    .clk(clk), .addr(tc_addr), .we(tc_we), .wdata(tc_wdata), .rdata(tc_rdata));
  mpam_ram #(.WIDTH(HIT_W), .DEPTH(MAX_NODES)) u_hits (
    .clk(clk), .addr(hc_addr), .we(hc_we), .wdata(hc_wdata), .rdata(hc_rdata));
  mpam_ram #(.WIDTH(NODE_W), .DEPTH(MAX_NODES)) u_queue (
    .clk(clk), .addr(q_addr), .we(q_we), .wdata(q_wdata), .rdata(q_rdata));
  mpam_ram #(.WIDTH(1), .DEPTH(MAX_NODES)) u_seen (
    .clk(clk), .addr(sn_addr), .we(sn_we), .wdata(sn_wdata), .rdata(sn_rdata));

  logic              take;
  logic              sym_ok;
  logic [NODE_W-1:0] ins_c;
  logic [NODE_W-1:0] bc, bg;
  logic [HIT_W:0]    hit_sum;
  logic [TERM_W:0]   match_sum;
  logic              last_idx;

  assign in_stall  = (state_r != ST_IDLE) || (out_valid_r && out_stall);
  assign take      = in_valid && !in_stall;
  assign sym_ok    = 32'(in_symbol) < ALPHABET;
  assign ins_c     = ch_rdata[32'(sym_r)*NODE_W +: NODE_W];
  assign bc        = rowu_r[32'(idx_r)*NODE_W +: NODE_W];
  assign bg        = root_r ? '0 : rowf_r[32'(idx_r)*NODE_W +: NODE_W];
  assign hit_sum   = {1'b0, hc_rdata} + (HIT_W+1)'(tc_rdata);
  assign match_sum = {1'b0, match_r} + {1'b0, tc_rdata};
  assign last_idx  = 32'(idx_r) == ALPHABET - 1;

  always_comb begin
    state_nxt = state_r;
    sym_nxt = sym_r;       sel_nxt = sel_r;
    ins_nxt = ins_r;       scan_nxt = scan_r;    nu_nxt = nu_r;
    addr_nxt = addr_r;     reply_nxt = reply_r;
    k_nxt = k_r;           steps_nxt = steps_r;  match_nxt = match_r;
    head_nxt = head_r;     tail_nxt = tail_r;
    u_nxt = u_r;           f_nxt = f_r;          root_nxt = root_r;
    idx_nxt = idx_r;       rowu_nxt = rowu_r;    rowf_nxt = rowf_r;
    c_nxt = c_r;           g_nxt = g_r;
    fin = 1'b0;
    out_node_nxt = scan_r; out_match_nxt = '0;   out_hit_nxt = '0; out_err_nxt = 1'b0;
    ch_addr = '0; ch_we = 1'b0; ch_wdata = ch_rdata;
    fl_addr = '0; fl_we = 1'b0; fl_wdata = '0;
    tc_addr = '0; tc_we = 1'b0; tc_wdata = '0;
    hc_addr = '0; hc_we = 1'b0; hc_wdata = '0;
    q_addr  = '0; q_we  = 1'b0; q_wdata  = c_r;
    sn_addr = '0; sn_we = 1'b0; sn_wdata = 1'b0;

    unique case (state_r)
      ST_CLEAR: begin
        ch_addr = addr_r[NODE_W-1:0]; ch_we = 1'b1; ch_wdata = '0;
        fl_addr = addr_r[NODE_W-1:0]; fl_we = 1'b1;
        tc_addr = addr_r[NODE_W-1:0]; tc_we = 1'b1;
        hc_addr = addr_r[NODE_W-1:0]; hc_we = 1'b1;
        addr_nxt = addr_r + 1'b1;
        if (addr_r == CNT_W'(MAX_NODES - 1)) begin
          nu_nxt    = CNT_W'(1);
          ins_nxt   = '0;
          scan_nxt  = '0;
          state_nxt = ST_IDLE;
          if (reply_r) begin
            fin = 1'b1;
            out_node_nxt = '0;
          end
        end
      end

      ST_IDLE: begin
        if (take) begin
          sym_nxt = in_symbol;
          sel_nxt = in_node_select;
          case (in_opcode)
            OP_CLEAR: begin
              addr_nxt  = '0;
              reply_nxt = 1'b1;
              state_nxt = ST_CLEAR;
            end
            OP_PAT: begin
              if (sym_ok && (CNT_W'(ins_r) < CNT_W'(MAX_NODES))) begin
                ch_addr   = ins_r;
                state_nxt = ST_INS_WB;
              end else begin
                fin = 1'b1;
                out_node_nxt = ins_r;
              end
            end
            OP_END: begin
              tc_addr   = ins_r;
              state_nxt = ST_TERM_WB;
            end
            OP_BUILD: begin
              addr_nxt  = '0;
              state_nxt = ST_B_SWEEP;
            end
            OP_SCAN: begin
              if (sym_ok) begin
                ch_addr   = scan_r;
                state_nxt = ST_SCAN_ROW;
              end else begin
                fin = 1'b1;
              end
            end
            OP_READ: begin
              if (CNT_W'(in_node_select) < CNT_W'(MAX_NODES)) begin
                hc_addr   = in_node_select;
                state_nxt = ST_READ_WB;
              end else begin
                fin = 1'b1;
                out_node_nxt = in_node_select;
              end
            end
            default: begin
              fin = 1'b1;
            end
          endcase
        end
      end

      ST_INS_WB: begin
        state_nxt = ST_IDLE;
        fin = 1'b1;
        out_node_nxt = ins_r;
        if (ins_c != '0) begin
          ins_nxt = ins_c;
          out_node_nxt = ins_c;
        end else if (nu_r < CNT_W'(MAX_NODES)) begin
          ch_addr = ins_r;
          ch_we   = 1'b1;
          ch_wdata[32'(sym_r)*NODE_W +: NODE_W] = nu_r[NODE_W-1:0];
          ins_nxt = nu_r[NODE_W-1:0];
          nu_nxt  = nu_r + 1'b1;
          out_node_nxt = nu_r[NODE_W-1:0];
        end else begin
          out_err_nxt = 1'b1;
        end
      end

      ST_TERM_WB: begin
        tc_addr  = ins_r;
        tc_we    = tc_rdata != {TERM_W{1'b1}};
        tc_wdata = tc_rdata + 1'b1;
        ins_nxt  = '0;
        fin = 1'b1;
        out_node_nxt = '0;
        state_nxt = ST_IDLE;
      end

      ST_READ_WB: begin
        fin = 1'b1;
        out_node_nxt = sel_r;
        out_hit_nxt  = hc_rdata;
        state_nxt = ST_IDLE;
      end

      ST_SCAN_ROW: begin
        k_nxt     = ins_c;
        scan_nxt  = ins_c;
        steps_nxt = '0;
        match_nxt = '0;
        state_nxt = ST_WALK_RD;
      end

      ST_WALK_RD: begin
        tc_addr = k_r;
        hc_addr = k_r;
        fl_addr = k_r;
        state_nxt = ST_WALK_WB;
      end

      ST_WALK_WB: begin
        hc_addr  = k_r;
        hc_we    = 1'b1;
        hc_wdata = hit_sum[HIT_W] ? {HIT_W{1'b1}} : hit_sum[HIT_W-1:0];
        match_nxt = match_sum[TERM_W] ? {TERM_W{1'b1}} : match_sum[TERM_W-1:0];
        steps_nxt = steps_r + 1'b1;
        k_nxt     = fl_rdata;
        if (k_r == '0 || steps_r == CNT_W'(MAX_NODES - 1)
            || CNT_W'(fl_rdata) >= CNT_W'(MAX_NODES)) begin
          fin = 1'b1;
          out_match_nxt = match_sum[TERM_W] ? {TERM_W{1'b1}} : match_sum[TERM_W-1:0];
          state_nxt = ST_IDLE;
        end else begin
          state_nxt = ST_WALK_RD;
        end
      end

      ST_B_SWEEP: begin
        // clear visited bits; root starts visited
        sn_addr  = addr_r[NODE_W-1:0];
        sn_we    = 1'b1;
        sn_wdata = addr_r == '0;
        addr_nxt = addr_r + 1'b1;
        if (addr_r == CNT_W'(MAX_NODES - 1)) begin
          state_nxt = ST_B_INIT;
        end
      end

      ST_B_INIT: begin
        fl_addr  = '0;
        fl_we    = 1'b1;
        ch_addr  = '0;
        u_nxt    = '0;
        f_nxt    = '0;
        root_nxt = 1'b1;
        head_nxt = '0;
        tail_nxt = '0;
        state_nxt = ST_B_ROWU;
      end

      ST_B_ROWU: begin
        rowu_nxt  = ch_rdata;
        ch_addr   = f_r;
        state_nxt = ST_B_ROWF;
      end

      ST_B_ROWF: begin
        rowf_nxt  = ch_rdata;
        idx_nxt   = '0;
        state_nxt = ST_B_SYM;
      end

      ST_B_SYM: begin
        c_nxt = bc;
        g_nxt = bg;
        if (bc != '0 && CNT_W'(bc) < CNT_W'(MAX_NODES) && tail_r < CNT_W'(MAX_NODES)) begin
          sn_addr   = bc;
          state_nxt = ST_B_SEEN;
        end else begin
          // fill a missing link with the failure node's goto transition
          if (bc == '0) begin
            rowu_nxt[32'(idx_r)*NODE_W +: NODE_W] = bg;
          end
          idx_nxt   = idx_r + 1'b1;
          state_nxt = last_idx ? ST_B_WRROW : ST_B_SYM;
        end
      end

      ST_B_SEEN: begin
        if (!sn_rdata) begin
          sn_addr  = c_r;
          sn_we    = 1'b1;
          sn_wdata = 1'b1;
          fl_addr  = c_r;
          fl_we    = 1'b1;
          fl_wdata = g_r;
          q_addr   = tail_r[NODE_W-1:0];
          q_we     = 1'b1;
          tail_nxt = tail_r + 1'b1;
        end
        idx_nxt   = idx_r + 1'b1;
        state_nxt = last_idx ? ST_B_WRROW : ST_B_SYM;
      end

      ST_B_WRROW: begin
        ch_addr   = u_r;
        ch_we     = 1'b1;
        ch_wdata  = rowu_r;
        root_nxt  = 1'b0;
        state_nxt = ST_B_POP;
      end

      ST_B_POP: begin
        if (head_r < tail_r) begin
          q_addr    = head_r[NODE_W-1:0];
          head_nxt  = head_r + 1'b1;
          state_nxt = ST_B_GETU;
        end else begin
          scan_nxt  = '0;
          fin = 1'b1;
          out_node_nxt = '0;
          state_nxt = ST_IDLE;
        end
      end

      ST_B_GETU: begin
        u_nxt     = q_rdata;
        fl_addr   = q_rdata;
        state_nxt = ST_B_GETF;
      end

      ST_B_GETF: begin
        f_nxt     = fl_rdata;
        ch_addr   = u_r;
        state_nxt = ST_B_ROWU;
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      addr_r      <= '0;
      reply_r     <= 1'b0;
      nu_r        <= CNT_W'(1);
      ins_r       <= '0;
      scan_r      <= '0;
      head_r      <= '0;
      tail_r      <= '0;
      root_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      addr_r  <= addr_nxt;
      reply_r <= reply_nxt;
      nu_r    <= nu_nxt;
      ins_r   <= ins_nxt;
      scan_r  <= scan_nxt;
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      root_r  <= root_nxt;
      if (fin) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    sym_r   <= sym_nxt;
    sel_r   <= sel_nxt;
    k_r     <= k_nxt;
    steps_r <= steps_nxt;
    match_r <= match_nxt;
    u_r     <= u_nxt;
    f_r     <= f_nxt;
    idx_r   <= idx_nxt;
    rowu_r  <= rowu_nxt;
    rowf_r  <= rowf_nxt;
    c_r     <= c_nxt;
    g_r     <= g_nxt;
    if (fin) begin
      out_node_r  <= out_node_nxt;
      out_match_r <= out_match_nxt;
      out_hit_r   <= out_hit_nxt;
      out_err_r   <= out_err_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_node         = out_node_r;
  assign out_matches_here = out_match_r;
  assign out_hit_count    = out_hit_r;
  assign out_error_code   = out_err_r;

  a_nodes_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_IDLE |-> (nu_r >= CNT_W'(1) && nu_r <= CNT_W'(MAX_NODES)))
    else $error("node count out of range");

  a_ins_alloc: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_IDLE |-> CNT_W'(ins_r) < nu_r)
    else $error("insert cursor beyond allocated nodes");

  a_queue_order: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_B_POP |-> (head_r <= tail_r && tail_r <= CNT_W'(MAX_NODES)))
    else $error("build queue pointers inconsistent");

  a_no_result_while_full: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |-> !fin)
    else $error("result produced while previous one is held");

endmodule
